@@ hdl/irqrr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IRQ redirection router package
// Shared constants, codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package irqrr_pkg;

	// Table geometry.
	localparam int NUM_ENTRIES = 24;
	localparam int OVR_SLOTS   = 24;

	localparam int IDX_W  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int SLOT_W = (OVR_SLOTS > 1) ? $clog2(OVR_SLOTS) : 1;
	localparam int USED_W = $clog2(OVR_SLOTS + 1);

	// Redirection entry bits.
	localparam logic [63:0] ENT_MASKED    = 64'h0000_0000_0001_0000;
	localparam logic [63:0] ENT_RESET_VAL = 64'h0000_0000_0001_00FF;
	localparam int          ENT_LEVEL_BIT = 15;
	localparam int          ENT_LOW_BIT   = 13;
	localparam logic [1:0]  FLAG_ASSERTED = 2'b11;

	// Command codes of an input transaction.
	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_MAP    = 2'd1,
		CMD_MASK   = 2'd2,
		CMD_UNMASK = 2'd3
	} cmd_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_WRITE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // append an override from the request
		logic capture;  // register the request and the resolved gsi
		logic read;     // range check and read the table entry
		logic commit;   // write the entry and load the result register
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_load;  // request at the input port is a load
	} dp_sts_t;

endpackage

@@ hdl/irqrr_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IRQ redirection router channel interfaces
// Valid/ready channels for requests, results and configuration writes.
// ----------------------------------------------------------------------------

// Request channel.
interface irqrr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] irq;
	logic [7:0] vector;
	logic [7:0] dest;
	logic [7:0] override_gsi;
	logic [3:0] override_flags;

	modport source (output valid, command, irq, vector, dest, override_gsi,
		override_flags, input ready);
	modport sink (input valid, command, irq, vector, dest, override_gsi,
		override_flags, output ready);
endinterface

// Result channel.
interface irqrr_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  gsi;
	logic [63:0] entry_value;
	logic        range_error;

	modport source (output valid, gsi, entry_value, range_error, input ready);
	modport sink (input valid, gsi, entry_value, range_error, output ready);
endinterface

// Configuration write channel for the table base gsi.
interface irqrr_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ hdl/irqrr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IRQ redirection router controller
// Sequences each request through capture, table read and table write, and
// owns the request ready and the result valid.
// ----------------------------------------------------------------------------
module irqrr_ctrl
	import irqrr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && !sts.is_load) state_nxt = ST_READ;
			end
			ST_READ: begin
				state_nxt = ST_WRITE;
			end
			ST_WRITE: begin
				if (!out_valid_q || out_ready) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Outputs to the datapath and the request channel.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load    = in_valid && sts.is_load;
				cmd.capture = in_valid && !sts.is_load;
			end
			ST_READ: begin
				cmd.read = 1'b1;
			end
			ST_WRITE: begin
				cmd.commit = !out_valid_q || out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Result valid: set by a commit, cleared when the transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	// A commit never overwrites a result that is still waiting.
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("commit while result register is occupied");

	// A result is withdrawn only after it has been taken.
	a_valid_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid_q) |-> $past(out_ready))
		else $error("result dropped without a handshake");

	// Each capture is followed by the table read in the next cycle.
	a_capture_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.read)
		else $error("capture not followed by a read");

	// No request is taken while one is still in the read or write step.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.read || cmd.commit) |-> !in_ready)
		else $error("request accepted during processing");
`endif

endmodule

@@ hdl/irqrr_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IRQ redirection router datapath
// Holds the override slots, the redirection table, the base register and
// the result register; resolves and updates entries on controller command.
// ----------------------------------------------------------------------------
module irqrr_dp
	import irqrr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  logic [1:0]  req_command,
	input  logic [7:0]  req_irq,
	input  logic [7:0]  req_vector,
	input  logic [7:0]  req_dest,
	input  logic [7:0]  req_override_gsi,
	input  logic [3:0]  req_override_flags,
	input  logic        cfg_wr,
	input  logic [7:0]  cfg_data,
	output logic [7:0]  rsp_gsi,
	output logic [63:0] rsp_entry_value,
	output logic        rsp_range_error
);

	// Override slots and fill count.
	logic [7:0]        ovr_src_q [OVR_SLOTS];
	logic [7:0]        ovr_tgt_q [OVR_SLOTS];
	logic [3:0]        ovr_flg_q [OVR_SLOTS];
	logic [USED_W-1:0] ovr_used_q;

	// Redirection table and per-entry written flags.
	logic [63:0]            table_mem [NUM_ENTRIES];
	logic [NUM_ENTRIES-1:0] ent_written_q;

	logic [7:0]  entry_base_q;

	// Captured request.
	cmd_t        cmd_q;
	logic [7:0]  gsi_q;
	logic [3:0]  flags_q;
	logic [7:0]  vector_q;
	logic [7:0]  dest_q;

	// Read step results.
	logic [IDX_W-1:0] idx_q;
	logic             range_err_q;
	logic [63:0]      rd_data_q;
	logic             ent_hit_q;

	// Result register.
	logic [7:0]  out_gsi_q;
	logic [63:0] out_val_q;
	logic        out_err_q;

	logic [7:0]  hit_gsi;
	logic [3:0]  hit_flags;
	logic [8:0]  diff;
	logic [63:0] cur_val;
	logic [63:0] new_val;

	assign sts.is_load = (cmd_t'(req_command) == CMD_LOAD);

	// Base register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_base_q <= 8'd0;
		end else if (cfg_wr) begin
			entry_base_q <= cfg_data;
		end
	end

	// Fill count of the override slots.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovr_used_q <= '0;
		end else if (cmd.load && (ovr_used_q < USED_W'(OVR_SLOTS))) begin
			ovr_used_q <= ovr_used_q + USED_W'(1);
		end
	end

	// Override slot storage; a load into a full table is dropped.
	always_ff @(posedge clk) begin
		if (cmd.load && (ovr_used_q < USED_W'(OVR_SLOTS))) begin
			ovr_src_q[ovr_used_q[SLOT_W-1:0]] <= req_irq;
			ovr_tgt_q[ovr_used_q[SLOT_W-1:0]] <= req_override_gsi;
			ovr_flg_q[ovr_used_q[SLOT_W-1:0]] <= req_override_flags;
		end
	end

	// Parallel compare of all loaded slots; the lowest matching slot wins.
	always_comb begin
		hit_gsi   = req_irq;
		hit_flags = 4'd0;
		for (int i = OVR_SLOTS - 1; i >= 0; i--) begin
			if ((USED_W'(i) < ovr_used_q) && (ovr_src_q[i] == req_irq)) begin
				hit_gsi   = ovr_tgt_q[i];
				hit_flags = ovr_flg_q[i];
			end
		end
	end

	// Capture the request with its resolved gsi and flags.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q    <= cmd_t'(req_command);
			gsi_q    <= hit_gsi;
			flags_q  <= hit_flags;
			vector_q <= req_vector;
			dest_q   <= req_dest;
		end
	end

	// Offset of the gsi from the base; a borrow means below the table.
	assign diff = {1'b0, gsi_q} - {1'b0, entry_base_q};

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			idx_q       <= diff[IDX_W-1:0];
			range_err_q <= diff[8] || ({1'b0, diff[7:0]} >= 9'(NUM_ENTRIES));
			ent_hit_q   <= ent_written_q[diff[IDX_W-1:0]];
		end
	end

	// Table memory: registered read in the read step, write on commit.
	always_ff @(posedge clk) begin
		if (cmd.read) begin
			rd_data_q <= table_mem[diff[IDX_W-1:0]];
		end
		if (cmd.commit && !range_err_q) begin
			table_mem[idx_q] <= new_val;
		end
	end

	// Written flags; an entry never written reads as the reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_written_q <= '0;
		end else if (cmd.commit && !range_err_q) begin
			ent_written_q[idx_q] <= 1'b1;
		end
	end

	assign cur_val = ent_hit_q ? rd_data_q : ENT_RESET_VAL;

	// New entry value for map, mask and unmask.
	always_comb begin
		new_val = cur_val;
		unique case (cmd_q)
			CMD_MAP: begin
				new_val                = '0;
				new_val[7:0]           = vector_q;
				new_val[ENT_LOW_BIT]   = (flags_q[1:0] == FLAG_ASSERTED);
				new_val[ENT_LEVEL_BIT] = (flags_q[3:2] == FLAG_ASSERTED);
				new_val[63:56]         = dest_q;
			end
			CMD_MASK: begin
				new_val = cur_val | ENT_MASKED;
			end
			CMD_UNMASK: begin
				new_val = cur_val & ~ENT_MASKED;
			end
			CMD_LOAD: begin
				new_val = cur_val;
			end
			default: begin
				new_val = cur_val;
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_gsi_q <= gsi_q;
			out_val_q <= range_err_q ? 64'd0 : new_val;
			out_err_q <= range_err_q;
		end
	end

	assign rsp_gsi         = out_gsi_q;
	assign rsp_entry_value = out_val_q;
	assign rsp_range_error = out_err_q;

endmodule

@@ hdl/irq_redirection_router.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IRQ redirection router
// Source-override table and redirection table with map, mask and unmask.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// req       in         command, irq, vector, dest, override_gsi, override_flags
// rsp       out        gsi, entry_value, range_error
// cfg       in         data (table base gsi)
//
// A load gives no result; map, mask and unmask pass through acceptance with
// the parallel override compare, the table read, then the table write into
// the result register.
// The result register frees the request side; a further result waits in the
// write step until the previous one is taken.
// Reset clears the override count, the base and the entry written flags.
// Configuration writes are always ready.
// ----------------------------------------------------------------------------
module irq_redirection_router
	import irqrr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	irqrr_in_if.sink    req,
	irqrr_out_if.source rsp,
	irqrr_cfg_if.sink   cfg
);

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	assign cfg.ready = 1'b1;

	// Controller.
	irqrr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	// Datapath.
	irqrr_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (dp_cmd),
		.sts                (dp_sts),
		.req_command        (req.command),
		.req_irq            (req.irq),
		.req_vector         (req.vector),
		.req_dest           (req.dest),
		.req_override_gsi   (req.override_gsi),
		.req_override_flags (req.override_flags),
		.cfg_wr             (cfg.valid),
		.cfg_data           (cfg.data),
		.rsp_gsi            (rsp.gsi),
		.rsp_entry_value    (rsp.entry_value),
		.rsp_range_error    (rsp.range_error)
	);

endmodule

@@ test/irq_redirection_router_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IRQ redirection router checker
// Watches the request, result and configuration channels, keeps its own copy
// of the override and redirection tables, predicts every result and compares
// it field by field with what the router returns.
// ----------------------------------------------------------------------------
module irq_redirection_router_checker
	import irqrr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	irqrr_in_if  req,
	irqrr_out_if rsp,
	irqrr_cfg_if cfg,
	output int   mismatches,
	output int   outstanding,
	output int   results_seen
);

	typedef struct packed {
		logic [7:0]  gsi;
		logic [63:0] entry_value;
		logic        range_error;
	} route_result_t;

	// Shadow copy of the router state.
	logic [7:0]    base_gsi;
	logic [7:0]    src_slot [OVR_SLOTS];
	logic [7:0]    target_slot [OVR_SLOTS];
	logic [3:0]    flag_slot [OVR_SLOTS];
	int            slots_used;
	logic [63:0]   entry_shadow [NUM_ENTRIES];

	route_result_t expected_routes [$];
	route_result_t oldest_route;
	int            fail_total;
	int            seen_total;

	// Apply one request to the shadow tables and queue the result it causes.
	task automatic predict_route(input cmd_t cmd, input logic [7:0] irq,
		input logic [7:0] vec, input logic [7:0] dst, input logic [7:0] tgt,
		input logic [3:0] flg);
		route_result_t res;
		logic [7:0]    gsi;
		logic [3:0]    flags;
		logic          hit;
		int            idx;
		if (cmd == CMD_LOAD) begin
			// A load into a full override table is dropped.
			if (slots_used < OVR_SLOTS) begin
				src_slot[slots_used]    = irq;
				target_slot[slots_used] = tgt;
				flag_slot[slots_used]   = flg;
				slots_used++;
			end
		end else begin
			// The first matching override wins; otherwise the irq is the gsi.
			gsi   = irq;
			flags = '0;
			hit   = 1'b0;
			for (int i = 0; i < slots_used; i++) begin
				if (!hit && src_slot[i] == irq) begin
					hit   = 1'b1;
					gsi   = target_slot[i];
					flags = flag_slot[i];
				end
			end
			idx = int'(gsi) - int'(base_gsi);
			res.gsi = gsi;
			if (idx < 0 || idx >= NUM_ENTRIES) begin
				res.entry_value = '0;
				res.range_error = 1'b1;
			end else begin
				case (cmd)
					CMD_MAP: begin
						res.entry_value = {dst, 48'd0, vec};
						res.entry_value[ENT_LOW_BIT]   = (flags[1:0] == FLAG_ASSERTED);
						res.entry_value[ENT_LEVEL_BIT] = (flags[3:2] == FLAG_ASSERTED);
					end
					CMD_MASK: begin
						res.entry_value = entry_shadow[idx] | ENT_MASKED;
					end
					default: begin
						res.entry_value = entry_shadow[idx] & ~ENT_MASKED;
					end
				endcase
				res.range_error   = 1'b0;
				entry_shadow[idx] = res.entry_value;
			end
			expected_routes.push_back(res);
		end
	endtask

	// Compare results first, then track configuration and new requests.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_gsi   = '0;
			slots_used = 0;
			for (int i = 0; i < NUM_ENTRIES; i++)
				entry_shadow[i] = ENT_RESET_VAL;
			expected_routes.delete();
			fail_total = 0;
			seen_total = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				seen_total++;
				if (expected_routes.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual gsi %0d value %h err %b",
						$time, rsp.gsi, rsp.entry_value, rsp.range_error);
					fail_total++;
				end else begin
					oldest_route = expected_routes.pop_front();
					if (rsp.gsi !== oldest_route.gsi) begin
						$display("%0t: gsi mismatch, expected %0d, actual %0d",
							$time, oldest_route.gsi, rsp.gsi);
						fail_total++;
					end
					if (rsp.entry_value !== oldest_route.entry_value) begin
						$display("%0t: entry_value mismatch, expected %h, actual %h",
							$time, oldest_route.entry_value, rsp.entry_value);
						fail_total++;
					end
					if (rsp.range_error !== oldest_route.range_error) begin
						$display("%0t: range_error mismatch, expected %b, actual %b",
							$time, oldest_route.range_error, rsp.range_error);
						fail_total++;
					end
				end
			end
			if (cfg.valid && cfg.ready)
				base_gsi = cfg.data;
			if (req.valid && req.ready)
				predict_route(cmd_t'(req.command), req.irq, req.vector, req.dest,
					req.override_gsi, req.override_flags);
		end
		mismatches   <= fail_total;
		outstanding  <= expected_routes.size();
		results_seen <= seen_total;
	end

endmodule

@@ test/irq_redirection_router_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IRQ redirection router testbench
// Drives directed and random override loads, maps, masks and unmasks through
// several table base settings with bursty requests and a stalling receiver;
// the checker beside the router predicts and compares every result.
// ----------------------------------------------------------------------------
module irq_redirection_router_tb
	import irqrr_pkg::*;
();

	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 80;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 150;
	localparam int IDLE_LIMIT    = 2000;

	typedef struct packed {
		cmd_t       command;
		logic [7:0] irq;
		logic [7:0] vector;
		logic [7:0] dest;
		logic [7:0] override_gsi;
		logic [3:0] override_flags;
	} route_req_t;

	logic clk;
	logic arst_n;

	irqrr_in_if  req_ch ();
	irqrr_out_if rsp_ch ();
	irqrr_cfg_if cfg_ch ();

	int mismatches;
	int outstanding;
	int results_seen;

	irq_redirection_router u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	irq_redirection_router_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_ch),
		.rsp          (rsp_ch),
		.cfg          (cfg_ch),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen)
	);

	logic [7:0] loaded_src [$];
	logic [7:0] base_list [PHASES] = '{8'd0, 8'd7, 8'd232, 8'd255, 8'd100, 8'd0};
	int         burst_left;
	bit         steady_send;
	bit         hold_request;
	int         hold_left;
	int         rx_cycle;
	int         idle_cycles;
	int         requests_sent;
	int         dropped_loads;

	// Clock.
	always #2 clk = ~clk;

	// Receiver: a long hold-off on request, else a rotating stall pattern.
	always @(posedge clk) begin
		rx_cycle++;
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			case (rx_cycle[8:6])
				3'd1:    rsp_ch.ready <= ($urandom_range(0, 1) == 1);
				3'd2:    rsp_ch.ready <= (rx_cycle[1:0] == 2'd0);
				3'd3:    rsp_ch.ready <= ($urandom_range(0, 99) < 85);
				3'd5:    rsp_ch.ready <= ($urandom_range(0, 99) < 30);
				3'd6:    rsp_ch.ready <= rx_cycle[2];
				default: rsp_ch.ready <= 1'b1;
			endcase
		end
	end

	// Watchdog on cycles with no transaction on any channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
				$display("irq_redirection_router_tb: FAIL");
				$finish;
			end
		end
	end

	function automatic route_req_t make_req(input cmd_t cmd, input logic [7:0] irq,
		input logic [7:0] vec, input logic [7:0] dst, input logic [7:0] tgt,
		input logic [3:0] flg);
		route_req_t r;
		r.command        = cmd;
		r.irq            = irq;
		r.vector         = vec;
		r.dest           = dst;
		r.override_gsi   = tgt;
		r.override_flags = flg;
		return r;
	endfunction

	// Random request aimed mostly at loaded overrides and the live table window.
	function automatic route_req_t random_request(input logic [7:0] base);
		route_req_t r;
		int         pick;
		r.vector         = 8'($urandom);
		r.dest           = 8'($urandom);
		r.override_flags = 4'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 12)
			r.command = CMD_LOAD;
		else if (pick < 52)
			r.command = CMD_MAP;
		else if (pick < 76)
			r.command = CMD_MASK;
		else
			r.command = CMD_UNMASK;
		pick = $urandom_range(0, 99);
		if (pick < 40 && loaded_src.size() > 0)
			r.irq = loaded_src[$urandom_range(0, loaded_src.size() - 1)];
		else if (pick < 85)
			r.irq = base + 8'($urandom_range(0, NUM_ENTRIES - 1));
		else
			r.irq = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 40)
			r.override_gsi = 8'($urandom_range(0, 40));
		else if (pick < 80)
			r.override_gsi = 8'($urandom_range(224, 255));
		else
			r.override_gsi = 8'($urandom);
		return r;
	endfunction

	// Offer one request and hold it until the transaction; then maybe leave a gap.
	task automatic send_request(input route_req_t r);
		int gap;
		req_ch.valid          <= 1'b1;
		req_ch.command        <= r.command;
		req_ch.irq            <= r.irq;
		req_ch.vector         <= r.vector;
		req_ch.dest           <= r.dest;
		req_ch.override_gsi   <= r.override_gsi;
		req_ch.override_flags <= r.override_flags;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		requests_sent++;
		if (r.command == CMD_LOAD) begin
			if (loaded_src.size() < OVR_SLOTS)
				loaded_src.push_back(r.irq);
			else
				dropped_loads++;
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = steady_send ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(0, 12);
		end
	endtask

	// Wait for every expected result, then let a load still in flight retire.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_base(input logic [7:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Stimulus and verdict.
	initial begin
		route_req_t directed [$];
		route_req_t r;
		int         counted;

		clk                   = 1'b0;
		arst_n                = 1'b0;
		req_ch.valid          = 1'b0;
		req_ch.command        = CMD_LOAD;
		req_ch.irq            = '0;
		req_ch.vector         = '0;
		req_ch.dest           = '0;
		req_ch.override_gsi   = '0;
		req_ch.override_flags = '0;
		rsp_ch.ready          = 1'b0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.data           = '0;
		burst_left            = 0;
		steady_send           = 1'b0;
		hold_request          = 1'b0;
		hold_left             = 0;
		rx_cycle              = 0;
		idle_cycles           = 0;
		requests_sent         = 0;
		dropped_loads         = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset base: reset entries, table edges, range
		// errors, shadowed duplicate overrides and every flag combination.
		directed.push_back(make_req(CMD_MASK,   8'd3,   8'h00, 8'h00, 8'h00, 4'h0));
		directed.push_back(make_req(CMD_UNMASK, 8'd3,   8'h00, 8'h00, 8'h00, 4'h0));
		directed.push_back(make_req(CMD_MAP,    8'd0,   8'h00, 8'h00, 8'h00, 4'h0));
		directed.push_back(make_req(CMD_MAP,    8'd23,  8'hFF, 8'hFF, 8'h00, 4'h0));
		directed.push_back(make_req(CMD_MAP,    8'd24,  8'h12, 8'h34, 8'h00, 4'h0));
		directed.push_back(make_req(CMD_MASK,   8'd255, 8'h00, 8'h00, 8'h00, 4'h0));
		directed.push_back(make_req(CMD_UNMASK, 8'd23,  8'h00, 8'h00, 8'h00, 4'h0));
		directed.push_back(make_req(CMD_MASK,   8'd23,  8'h00, 8'h00, 8'h00, 4'h0));
		directed.push_back(make_req(CMD_LOAD,   8'd9,   8'h00, 8'h00, 8'd2,   4'h3));
		directed.push_back(make_req(CMD_LOAD,   8'd9,   8'h00, 8'h00, 8'd4,   4'hF));
		directed.push_back(make_req(CMD_LOAD,   8'd10,  8'h00, 8'h00, 8'd5,   4'hC));
		directed.push_back(make_req(CMD_LOAD,   8'd11,  8'h00, 8'h00, 8'd200, 4'h5));
		directed.push_back(make_req(CMD_LOAD,   8'd12,  8'h00, 8'h00, 8'd6,   4'hF));
		directed.push_back(make_req(CMD_LOAD,   8'd255, 8'h00, 8'h00, 8'd0,   4'hA));
		directed.push_back(make_req(CMD_LOAD,   8'd200, 8'h00, 8'h00, 8'd255, 4'h0));
		directed.push_back(make_req(CMD_MAP,    8'd9,   8'h5A, 8'h81, 8'h00, 4'h0));
		directed.push_back(make_req(CMD_MAP,    8'd10,  8'hA5, 8'h7E, 8'h00, 4'h0));
		directed.push_back(make_req(CMD_MAP,    8'd11,  8'h11, 8'h22, 8'h00, 4'h0));
		directed.push_back(make_req(CMD_MAP,    8'd12,  8'h33, 8'h44, 8'h00, 4'h0));
		directed.push_back(make_req(CMD_MAP,    8'd255, 8'h55, 8'h66, 8'h00, 4'h0));
		directed.push_back(make_req(CMD_MAP,    8'd200, 8'h77, 8'h88, 8'h00, 4'h0));
		directed.push_back(make_req(CMD_MASK,   8'd12,  8'h00, 8'h00, 8'h00, 4'h0));
		directed.push_back(make_req(CMD_UNMASK, 8'd9,   8'h00, 8'h00, 8'h00, 4'h0));
		directed.push_back(make_req(CMD_MAP,    8'd2,   8'hC3, 8'h3C, 8'h00, 4'h0));
		foreach (directed[i])
			send_request(directed[i]);

		// Random phases, one table base setting each, written while idle.
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			write_base(base_list[p]);
			if (p == 2) begin
				// Receiver holds off while requests keep coming back to back.
				steady_send  = 1'b1;
				hold_request = 1'b1;
			end
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				if (p == 3 && counted == PHASE_ITEMS / 2)
					wait_drained();
				r = random_request(base_list[p]);
				if (!(r.command == CMD_LOAD && loaded_src.size() >= OVR_SLOTS))
					counted++;
				send_request(r);
			end
			steady_send = 1'b0;
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d requests, %0d of them loads dropped on a full table,",
			requests_sent, dropped_loads);
		$display("and %0d results over table bases 0, 7, 232, 255, 100 with %0d overrides.",
			results_seen, loaded_src.size());
		if (mismatches == 0 && outstanding == 0)
			$display("irq_redirection_router_tb: PASS");
		else
			$display("irq_redirection_router_tb: FAIL");
		$finish;
	end

endmodule
